// ----- hdl/hrbp_pkg.sv -----
// types and constants shared by the request byte parser
package hrbp_pkg;

	typedef enum logic [4:0] {
		ST_METHOD_START,
		ST_METHOD,
		ST_URI,
		ST_VER_H,
		ST_VER_T1,
		ST_VER_T2,
		ST_VER_P,
		ST_VER_SLASH,
		ST_MAJOR_START,
		ST_MAJOR,
		ST_MINOR_START,
		ST_MINOR,
		ST_NL1,
		ST_LINE_START,
		ST_LWS,
		ST_NAME,
		ST_SP_VALUE,
		ST_VALUE,
		ST_NL2,
		ST_NL3,
		ST_BODY
	} parse_state_t;

	typedef enum logic [1:0] {
		STATUS_MORE = 2'd0,
		STATUS_DONE = 2'd1,
		STATUS_BAD  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		CLASS_SYNTAX = 3'd0,
		CLASS_METHOD = 3'd1,
		CLASS_URI    = 3'd2,
		CLASS_NAME   = 3'd3,
		CLASS_VALUE  = 3'd4,
		CLASS_BODY   = 3'd5
	} byte_class_t;

	localparam logic [7:0] CHAR_CR = 8'h0d;
	localparam logic [7:0] CHAR_LF = 8'h0a;
	localparam logic [7:0] CHAR_SP = 8'h20;
	localparam logic [7:0] CHAR_TAB = 8'h09;
	localparam logic [7:0] CHAR_DEL = 8'h7f;
	localparam logic [7:0] CHAR_CTL_MAX = 8'h1f;
	localparam logic [7:0] CHAR_ASCII_MAX = 8'h7f;
	localparam logic [3:0] NAME_LEN = 4'd14;

	typedef struct packed {
		logic ctl;
		logic digit;
		logic token;
		logic ws;
	} hrbp_char_t;

	typedef struct packed {
		parse_state_t st;
		logic         any_header_seen;
		logic [3:0]   name_match_pos;
		logic         name_still_matches;
		logic         in_length_header;
		logic         length_header_found;
		logic         length_digits_ended;
		logic         length_digits_seen;
		logic [7:0]   major_count;
		logic [7:0]   minor_count;
	} hrbp_ctl_t;

	localparam hrbp_ctl_t CTL_RESET = '{
		st: ST_METHOD_START,
		any_header_seen: 1'b0,
		name_match_pos: 4'd0,
		name_still_matches: 1'b1,
		in_length_header: 1'b0,
		length_header_found: 1'b0,
		length_digits_ended: 1'b0,
		length_digits_seen: 1'b0,
		major_count: 8'd0,
		minor_count: 8'd0
	};

	typedef struct packed {
		status_t     status;
		byte_class_t cls;
		logic        header_begin;
		logic [7:0]  major_version;
		logic [7:0]  minor_version;
	} hrbp_res_t;

endpackage

// ----- hdl/hrbp_if.sv -----
// byte request and result channel interfaces
interface hrbp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;

	modport source(output valid, output byte_in, input ready);
	modport sink(input valid, input byte_in, output ready);
endinterface

interface hrbp_result_if #(
	parameter int LENGTH_BITS = 31
);
	logic                   valid;
	logic                   ready;
	logic [1:0]             status;
	logic [2:0]             byte_class;
	logic [7:0]             byte_out;
	logic                   header_begin;
	logic [7:0]             major_version;
	logic [7:0]             minor_version;
	logic [LENGTH_BITS-1:0] body_length;

	modport source(output valid, output status, output byte_class, output byte_out,
		output header_begin, output major_version, output minor_version,
		output body_length, input ready);
	modport sink(input valid, input status, input byte_class, input byte_out,
		input header_begin, input major_version, input minor_version,
		input body_length, output ready);
endinterface

// ----- hdl/hrbp_char_class.sv -----
// character class decode for one request byte
module hrbp_char_class import hrbp_pkg::*; (
	input  logic [7:0] c,
	output hrbp_char_t flags
);

	logic special;

	always_comb begin
		unique case (c)
			"(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"",
			"/", "[", "]", "?", "=", "{", "}", CHAR_SP, CHAR_TAB: special = 1'b1;
			default: special = 1'b0;
		endcase
	end

	always_comb begin
		flags.ctl = (c <= CHAR_CTL_MAX) || (c == CHAR_DEL);
		flags.digit = (c >= "0") && (c <= "9");
		flags.token = (c <= CHAR_ASCII_MAX) && !flags.ctl && !special;
		flags.ws = (c == CHAR_SP) || (c == CHAR_TAB);
	end

endmodule

// ----- hdl/hrbp_step.sv -----
// one parse step: next state, byte class, header match and counters
module hrbp_step import hrbp_pkg::*; #(
	parameter int LENGTH_BITS = 31
) (
	input  logic [7:0]             c,
	input  hrbp_char_t             flags,
	input  hrbp_ctl_t              ctl,
	input  logic [LENGTH_BITS-1:0] length_value,
	input  logic [LENGTH_BITS-1:0] body_count,
	output hrbp_ctl_t              ctl_next,
	output logic [LENGTH_BITS-1:0] length_next,
	output logic [LENGTH_BITS-1:0] body_next,
	output hrbp_res_t              res,
	output logic [LENGTH_BITS-1:0] length_shown
);

	localparam int WIDE = LENGTH_BITS + 4;
	localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

	function automatic logic [7:0] name_char(input logic [3:0] pos);
		logic [7:0] r;
		unique case (pos)
			4'd0:  r = "c";
			4'd1:  r = "o";
			4'd2:  r = "n";
			4'd3:  r = "t";
			4'd4:  r = "e";
			4'd5:  r = "n";
			4'd6:  r = "t";
			4'd7:  r = "-";
			4'd8:  r = "l";
			4'd9:  r = "e";
			4'd10: r = "n";
			4'd11: r = "g";
			4'd12: r = "t";
			4'd13: r = "h";
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	parse_state_t st_next;
	logic         bad;

	logic [7:0]       lc;
	logic [3:0]       feed_pos;
	logic             feed_match;
	logic             name_hit;
	logic [3:0]       d;
	logic [11:0]      major_wide;
	logic [11:0]      minor_wide;
	logic [7:0]       major_inc;
	logic [7:0]       minor_inc;
	logic [WIDE-1:0]  length_wide;
	logic [LENGTH_BITS-1:0] length_inc;
	logic [LENGTH_BITS-1:0] body_inc;
	hrbp_ctl_t        upd;
	logic [LENGTH_BITS-1:0] len_upd;
	logic [LENGTH_BITS-1:0] body_upd;
	status_t          status;
	byte_class_t      cls;
	logic             hb;
	logic             value_feed;

	// next parse state and malformed detect
	always_comb begin
		st_next = ctl.st;
		bad = 1'b0;
		unique case (ctl.st)
			ST_METHOD_START: begin
				if (flags.token) st_next = ST_METHOD;
				else bad = 1'b1;
			end
			ST_METHOD: begin
				if (c == CHAR_SP) st_next = ST_URI;
				else if (!flags.token) bad = 1'b1;
			end
			ST_URI: begin
				if (c == CHAR_SP) st_next = ST_VER_H;
				else if (flags.ctl) bad = 1'b1;
			end
			ST_VER_H: begin
				if (c == "H") st_next = ST_VER_T1;
				else bad = 1'b1;
			end
			ST_VER_T1: begin
				if (c == "T") st_next = ST_VER_T2;
				else bad = 1'b1;
			end
			ST_VER_T2: begin
				if (c == "T") st_next = ST_VER_P;
				else bad = 1'b1;
			end
			ST_VER_P: begin
				if (c == "P") st_next = ST_VER_SLASH;
				else bad = 1'b1;
			end
			ST_VER_SLASH: begin
				if (c == "/") st_next = ST_MAJOR_START;
				else bad = 1'b1;
			end
			ST_MAJOR_START: begin
				if (flags.digit) st_next = ST_MAJOR;
				else bad = 1'b1;
			end
			ST_MAJOR: begin
				if (c == ".") st_next = ST_MINOR_START;
				else if (!flags.digit) bad = 1'b1;
			end
			ST_MINOR_START: begin
				if (flags.digit) st_next = ST_MINOR;
				else bad = 1'b1;
			end
			ST_MINOR: begin
				if (c == CHAR_CR) st_next = ST_NL1;
				else if (!flags.digit) bad = 1'b1;
			end
			ST_NL1: begin
				if (c == CHAR_LF) st_next = ST_LINE_START;
				else bad = 1'b1;
			end
			ST_LINE_START: begin
				if (c == CHAR_CR) st_next = ST_NL3;
				else if (ctl.any_header_seen && flags.ws) st_next = ST_LWS;
				else if (!flags.token) bad = 1'b1;
				else st_next = ST_NAME;
			end
			ST_LWS: begin
				if (c == CHAR_CR) st_next = ST_NL2;
				else if (flags.ws) st_next = ST_LWS;
				else if (flags.ctl) bad = 1'b1;
				else st_next = ST_VALUE;
			end
			ST_NAME: begin
				if (c == ":") st_next = ST_SP_VALUE;
				else if (!flags.token) bad = 1'b1;
			end
			ST_SP_VALUE: begin
				if (c == CHAR_SP) st_next = ST_VALUE;
				else bad = 1'b1;
			end
			ST_VALUE: begin
				if (c == CHAR_CR) st_next = ST_NL2;
				else if (flags.ctl) bad = 1'b1;
			end
			ST_NL2: begin
				if (c == CHAR_LF) st_next = ST_LINE_START;
				else bad = 1'b1;
			end
			ST_NL3: begin
				if (c == CHAR_LF) st_next = ST_BODY;
				else bad = 1'b1;
			end
			ST_BODY: st_next = ST_BODY;
			default: bad = 1'b1;
		endcase
	end

	// arithmetic helpers
	always_comb begin
		d = c[3:0] - 4'd0;
		lc = ((c >= "A") && (c <= "Z")) ? c + 8'd32 : c;
		feed_pos = (ctl.st == ST_LINE_START) ? 4'd0 : ctl.name_match_pos;
		feed_match = (ctl.st == ST_LINE_START) ? 1'b1 : ctl.name_still_matches;
		name_hit = feed_match && (feed_pos < NAME_LEN) && (name_char(feed_pos) == lc);
		major_wide = ({4'd0, ctl.major_count} << 3) + ({4'd0, ctl.major_count} << 1)
			+ {8'd0, d};
		minor_wide = ({4'd0, ctl.minor_count} << 3) + ({4'd0, ctl.minor_count} << 1)
			+ {8'd0, d};
		major_inc = (major_wide > 12'd255) ? 8'd255 : major_wide[7:0];
		minor_inc = (minor_wide > 12'd255) ? 8'd255 : minor_wide[7:0];
		length_wide = ({4'd0, length_value} << 3) + ({4'd0, length_value} << 1)
			+ WIDE'(d);
		length_inc = (length_wide > {4'd0, LEN_MAX}) ? LEN_MAX
			: length_wide[LENGTH_BITS-1:0];
		body_inc = (body_count < LEN_MAX) ? body_count + 1'b1 : body_count;
	end

	// field updates and result
	always_comb begin
		upd = ctl;
		upd.st = st_next;
		len_upd = length_value;
		body_upd = body_count;
		status = STATUS_MORE;
		cls = CLASS_SYNTAX;
		hb = 1'b0;
		value_feed = 1'b0;
		unique case (ctl.st)
			ST_METHOD_START, ST_METHOD: begin
				if (flags.token) cls = CLASS_METHOD;
			end
			ST_URI: begin
				if (c != CHAR_SP && !flags.ctl) cls = CLASS_URI;
			end
			ST_MAJOR_START, ST_MAJOR: begin
				if (flags.digit) upd.major_count = major_inc;
			end
			ST_MINOR_START, ST_MINOR: begin
				if (flags.digit) upd.minor_count = minor_inc;
			end
			ST_LINE_START: begin
				if (st_next == ST_NAME) begin
					upd.any_header_seen = 1'b1;
					upd.in_length_header = 1'b0;
					upd.name_match_pos = name_hit ? feed_pos + 4'd1 : feed_pos;
					upd.name_still_matches = name_hit;
					cls = CLASS_NAME;
					hb = 1'b1;
				end
			end
			ST_NAME: begin
				if (c == ":") begin
					if (ctl.name_still_matches && ctl.name_match_pos == NAME_LEN
						&& !ctl.length_header_found) begin
						upd.length_header_found = 1'b1;
						upd.in_length_header = 1'b1;
					end
				end else if (flags.token) begin
					if (ctl.name_still_matches) begin
						upd.name_match_pos = name_hit ? feed_pos + 4'd1 : feed_pos;
						upd.name_still_matches = name_hit;
					end
					cls = CLASS_NAME;
				end
			end
			ST_LWS: begin
				if (st_next == ST_VALUE) begin
					cls = CLASS_VALUE;
					value_feed = 1'b1;
				end
			end
			ST_VALUE: begin
				if (c != CHAR_CR && !flags.ctl) begin
					cls = CLASS_VALUE;
					value_feed = 1'b1;
				end
			end
			ST_NL3: begin
				if (c == CHAR_LF && length_value == '0) status = STATUS_DONE;
			end
			ST_BODY: begin
				cls = CLASS_BODY;
				body_upd = body_inc;
				if (body_inc >= length_value) status = STATUS_DONE;
			end
			default: ;
		endcase

		if (value_feed && ctl.in_length_header && !ctl.length_digits_ended) begin
			if (flags.ws) begin
				if (ctl.length_digits_seen) upd.length_digits_ended = 1'b1;
			end else if (flags.digit) begin
				upd.length_digits_seen = 1'b1;
				len_upd = length_inc;
			end else begin
				upd.length_digits_ended = 1'b1;
			end
		end

		if (bad) begin
			status = STATUS_BAD;
			cls = CLASS_SYNTAX;
			hb = 1'b0;
		end
	end

	always_comb begin
		res.status = status;
		res.cls = cls;
		res.header_begin = hb;
		res.major_version = upd.major_count;
		res.minor_version = upd.minor_count;
		length_shown = len_upd;
		if (status != STATUS_MORE) begin
			ctl_next = CTL_RESET;
			length_next = '0;
			body_next = '0;
		end else begin
			ctl_next = upd;
			length_next = len_upd;
			body_next = body_upd;
		end
	end

endmodule

// ----- hdl/http_request_byte_parser_unit.sv -----
// HTTP request byte parser: one result per request byte. A byte taken on byte_chan is held in
// an input register; when it advances, the parse step updates the parser state and loads the
// result register, so each byte's result is offered once it has passed both registers. One
// byte is accepted every cycle while results drain; the only loop is the parse state update,
// and byte_chan.ready drops only while a result waits and result_chan.ready is low.
module http_request_byte_parser_unit import hrbp_pkg::*; #(
	parameter int LENGTH_BITS = 31
) (
	input logic            clk,
	input logic            arst_n,
	hrbp_byte_if.sink      byte_chan,
	hrbp_result_if.source  result_chan
);

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   valid_s2;
	hrbp_res_t              res_s2;
	logic [7:0]             byte_s2;
	logic [LENGTH_BITS-1:0] length_s2;

	hrbp_ctl_t              ctl_q;
	logic [LENGTH_BITS-1:0] length_q;
	logic [LENGTH_BITS-1:0] body_q;

	hrbp_char_t             flags;
	hrbp_ctl_t              ctl_next;
	logic [LENGTH_BITS-1:0] length_next;
	logic [LENGTH_BITS-1:0] body_next;
	hrbp_res_t              res;
	logic [LENGTH_BITS-1:0] length_shown;
	logic                   advance;

	assign advance = valid_s1 && (!valid_s2 || result_chan.ready);
	assign byte_chan.ready = !valid_s1 || advance;

	hrbp_char_class u_char_class (
		.c     (byte_s1),
		.flags (flags)
	);

	hrbp_step #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_step (
		.c            (byte_s1),
		.flags        (flags),
		.ctl          (ctl_q),
		.length_value (length_q),
		.body_count   (body_q),
		.ctl_next     (ctl_next),
		.length_next  (length_next),
		.body_next    (body_next),
		.res          (res),
		.length_shown (length_shown)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			ctl_q <= CTL_RESET;
			length_q <= '0;
			body_q <= '0;
		end else begin
			if (byte_chan.ready) valid_s1 <= byte_chan.valid;
			if (advance) begin
				valid_s2 <= 1'b1;
				ctl_q <= ctl_next;
				length_q <= length_next;
				body_q <= body_next;
			end else if (result_chan.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_chan.ready && byte_chan.valid) byte_s1 <= byte_chan.byte_in;
		if (advance) begin
			res_s2 <= res;
			byte_s2 <= byte_s1;
			length_s2 <= length_shown;
		end
	end

	assign result_chan.valid = valid_s2;
	assign result_chan.status = res_s2.status;
	assign result_chan.byte_class = res_s2.cls;
	assign result_chan.byte_out = byte_s2;
	assign result_chan.header_begin = res_s2.header_begin;
	assign result_chan.major_version = res_s2.major_version;
	assign result_chan.minor_version = res_s2.minor_version;
	assign result_chan.body_length = length_s2;

endmodule

// ----- hdl/hrbp_checker.sv -----
// port-level checks for the request byte parser and their bind
module hrbp_checker import hrbp_pkg::*; #(
	parameter int LENGTH_BITS = 31
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [1:0]             status,
	input logic [2:0]             byte_class,
	input logic [7:0]             byte_out,
	input logic                   header_begin,
	input logic [LENGTH_BITS-1:0] body_length
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(byte_out)
			&& $stable(body_length))
		else $error("result changed while stalled");

	a_bad_syntax: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_BAD |-> byte_class == CLASS_SYNTAX && !header_begin)
		else $error("malformed result carries a class or header mark");

	a_header_begin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && header_begin |-> byte_class == CLASS_NAME && status == STATUS_MORE)
		else $error("header mark outside a header name");

	a_done_class: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_DONE
			|-> byte_class == CLASS_BODY || byte_class == CLASS_SYNTAX)
		else $error("completion on a byte that is neither body nor syntax");

endmodule

bind http_request_byte_parser_unit hrbp_checker #(
	.LENGTH_BITS(LENGTH_BITS)
) u_hrbp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (result_chan.valid),
	.out_ready    (result_chan.ready),
	.status       (result_chan.status),
	.byte_class   (result_chan.byte_class),
	.byte_out     (result_chan.byte_out),
	.header_begin (result_chan.header_begin),
	.body_length  (result_chan.body_length)
);

// ----- tb/http_request_byte_parser_unit_test.sv -----
// self-checking bench for the request byte parser: a directed byte table, then random requests
module http_request_byte_parser_unit_test;
	import hrbp_pkg::*;

	localparam int LENGTH_BITS = 31;
	localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = '1;
	localparam logic [8*14-1:0] LENGTH_NAME = "content-length";
	localparam int BYTE_TARGET = 874;
	localparam int QUIET_FROM = 720;
	localparam int HOLD_LENGTH = 150;

	typedef struct {
		status_t                status;
		byte_class_t            cls;
		logic [7:0]             data;
		logic                   header_begin;
		logic [7:0]             major;
		logic [7:0]             minor;
		logic [LENGTH_BITS-1:0] body_length;
	} parse_result_t;

	typedef struct {
		logic [7:0]  data;
		bit          pinned;
		status_t     status;
		byte_class_t cls;
	} opening_row_t;

	logic clk = 1'b0;
	logic arst_n;

	hrbp_byte_if byte_chan();
	hrbp_result_if #(.LENGTH_BITS(LENGTH_BITS)) result_chan();

	http_request_byte_parser_unit #(.LENGTH_BITS(LENGTH_BITS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_chan(byte_chan),
		.result_chan(result_chan)
	);

	// parser image
	parse_state_t           parser_state;
	bit                     any_header;
	logic [3:0]             match_pos;
	bit                     match_ok;
	bit                     in_length;
	bit                     length_found;
	bit                     digits_ended;
	bit                     digits_seen;
	logic [LENGTH_BITS-1:0] length_value;
	logic [LENGTH_BITS-1:0] body_count;
	logic [7:0]             major_count;
	logic [7:0]             minor_count;

	parse_result_t pending_results[$];
	logic [7:0]    request_bytes[$];
	int errors = 0;
	int bytes_sent = 0;
	int results_seen = 0;
	int requests_done = 0;
	int requests_bad = 0;
	int hold_cycles = 0;
	int stall_left = 0;
	bit idle_on = 1'b1;
	bit gap_mode = 1'b1;

	opening_row_t opening_bytes [26] = '{
		'{8'h00, 1'b1, STATUS_BAD, CLASS_SYNTAX},
		'{8'hff, 1'b1, STATUS_BAD, CLASS_SYNTAX},
		'{"G", 1'b1, STATUS_MORE, CLASS_METHOD},
		'{CHAR_SP, 1'b0, STATUS_MORE, CLASS_SYNTAX},
		'{8'hff, 1'b1, STATUS_MORE, CLASS_URI},
		'{CHAR_SP, 1'b0, STATUS_MORE, CLASS_SYNTAX},
		'{"H", 1'b0, STATUS_MORE, CLASS_SYNTAX},
		'{"T", 1'b0, STATUS_MORE, CLASS_SYNTAX},
		'{"T", 1'b0, STATUS_MORE, CLASS_SYNTAX},
		'{"P", 1'b0, STATUS_MORE, CLASS_SYNTAX},
		'{"/", 1'b0, STATUS_MORE, CLASS_SYNTAX},
		'{"9", 1'b0, STATUS_MORE, CLASS_SYNTAX},
		'{"9", 1'b0, STATUS_MORE, CLASS_SYNTAX},
		'{"9", 1'b0, STATUS_MORE, CLASS_SYNTAX},
		'{".", 1'b0, STATUS_MORE, CLASS_SYNTAX},
		'{"0", 1'b0, STATUS_MORE, CLASS_SYNTAX},
		'{CHAR_CR, 1'b0, STATUS_MORE, CLASS_SYNTAX},
		'{CHAR_LF, 1'b0, STATUS_MORE, CLASS_SYNTAX},
		'{"K", 1'b1, STATUS_MORE, CLASS_NAME},
		'{":", 1'b0, STATUS_MORE, CLASS_SYNTAX},
		'{CHAR_SP, 1'b0, STATUS_MORE, CLASS_SYNTAX},
		'{"1", 1'b0, STATUS_MORE, CLASS_SYNTAX},
		'{CHAR_CR, 1'b0, STATUS_MORE, CLASS_SYNTAX},
		'{CHAR_LF, 1'b0, STATUS_MORE, CLASS_SYNTAX},
		'{CHAR_CR, 1'b0, STATUS_MORE, CLASS_SYNTAX},
		'{CHAR_LF, 1'b1, STATUS_DONE, CLASS_SYNTAX}
	};

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic bit control_char(logic [7:0] c);
		return c <= CHAR_CTL_MAX || c == CHAR_DEL;
	endfunction

	function automatic bit digit_char(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit token_char(logic [7:0] c);
		if (c > CHAR_ASCII_MAX || control_char(c))
			return 1'b0;
		case (c)
			"(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]", "?", "=",
			"{", "}", CHAR_SP, CHAR_TAB: return 1'b0;
			default: return 1'b1;
		endcase
	endfunction

	function automatic void clear_parser();
		parser_state = ST_METHOD_START;
		any_header = 1'b0;
		match_pos = '0;
		match_ok = 1'b1;
		in_length = 1'b0;
		length_found = 1'b0;
		digits_ended = 1'b0;
		digits_seen = 1'b0;
		length_value = '0;
		body_count = '0;
		major_count = '0;
		minor_count = '0;
	endfunction

	function automatic logic [7:0] version_step(logic [7:0] v, logic [7:0] c);
		int n;
		n = int'(v) * 10 + int'(c) - 48;
		return (n > 255) ? 8'd255 : 8'(n);
	endfunction

	function automatic void name_step(logic [7:0] c);
		logic [7:0] lc;
		lc = (c >= "A" && c <= "Z") ? c + 8'h20 : c;
		if (!match_ok)
			return;
		if (match_pos >= NAME_LEN || LENGTH_NAME[8 * (13 - int'(match_pos)) +: 8] != lc)
			match_ok = 1'b0;
		else
			match_pos++;
	endfunction

	function automatic void length_step(logic [7:0] c);
		longint n;
		if (!in_length || digits_ended)
			return;
		if (c == CHAR_SP || c == CHAR_TAB) begin
			if (digits_seen)
				digits_ended = 1'b1;
		end else if (digit_char(c)) begin
			n = longint'(length_value) * 10 + longint'(c) - 48;
			digits_seen = 1'b1;
			length_value = (n > longint'(LENGTH_MAX)) ? LENGTH_MAX : n[LENGTH_BITS-1:0];
		end else begin
			digits_ended = 1'b1;
		end
	endfunction

	function automatic parse_result_t parse_byte(logic [7:0] c);
		parse_result_t r;
		bit bad;
		r.status = STATUS_MORE;
		r.cls = CLASS_SYNTAX;
		r.data = c;
		r.header_begin = 1'b0;
		bad = 1'b0;
		case (parser_state)
			ST_METHOD_START: begin
				if (token_char(c)) begin
					parser_state = ST_METHOD;
					r.cls = CLASS_METHOD;
				end else
					bad = 1'b1;
			end
			ST_METHOD: begin
				if (c == CHAR_SP)
					parser_state = ST_URI;
				else if (token_char(c))
					r.cls = CLASS_METHOD;
				else
					bad = 1'b1;
			end
			ST_URI: begin
				if (c == CHAR_SP)
					parser_state = ST_VER_H;
				else if (control_char(c))
					bad = 1'b1;
				else
					r.cls = CLASS_URI;
			end
			ST_VER_H: if (c == "H") parser_state = ST_VER_T1; else bad = 1'b1;
			ST_VER_T1: if (c == "T") parser_state = ST_VER_T2; else bad = 1'b1;
			ST_VER_T2: if (c == "T") parser_state = ST_VER_P; else bad = 1'b1;
			ST_VER_P: if (c == "P") parser_state = ST_VER_SLASH; else bad = 1'b1;
			ST_VER_SLASH: if (c == "/") parser_state = ST_MAJOR_START; else bad = 1'b1;
			ST_MAJOR_START: begin
				if (digit_char(c)) begin
					major_count = version_step(major_count, c);
					parser_state = ST_MAJOR;
				end else
					bad = 1'b1;
			end
			ST_MAJOR: begin
				if (c == ".")
					parser_state = ST_MINOR_START;
				else if (digit_char(c))
					major_count = version_step(major_count, c);
				else
					bad = 1'b1;
			end
			ST_MINOR_START: begin
				if (digit_char(c)) begin
					minor_count = version_step(minor_count, c);
					parser_state = ST_MINOR;
				end else
					bad = 1'b1;
			end
			ST_MINOR: begin
				if (c == CHAR_CR)
					parser_state = ST_NL1;
				else if (digit_char(c))
					minor_count = version_step(minor_count, c);
				else
					bad = 1'b1;
			end
			ST_NL1: if (c == CHAR_LF) parser_state = ST_LINE_START; else bad = 1'b1;
			ST_LINE_START: begin
				if (c == CHAR_CR)
					parser_state = ST_NL3;
				else if (any_header && (c == CHAR_SP || c == CHAR_TAB))
					parser_state = ST_LWS;
				else if (!token_char(c))
					bad = 1'b1;
				else begin
					any_header = 1'b1;
					in_length = 1'b0;
					match_pos = '0;
					match_ok = 1'b1;
					name_step(c);
					parser_state = ST_NAME;
					r.cls = CLASS_NAME;
					r.header_begin = 1'b1;
				end
			end
			ST_LWS: begin
				if (c == CHAR_CR)
					parser_state = ST_NL2;
				else if (c == CHAR_SP || c == CHAR_TAB)
					;
				else if (control_char(c))
					bad = 1'b1;
				else begin
					parser_state = ST_VALUE;
					r.cls = CLASS_VALUE;
					length_step(c);
				end
			end
			ST_NAME: begin
				if (c == ":") begin
					if (match_ok && match_pos == NAME_LEN && !length_found) begin
						length_found = 1'b1;
						in_length = 1'b1;
					end
					parser_state = ST_SP_VALUE;
				end else if (token_char(c)) begin
					name_step(c);
					r.cls = CLASS_NAME;
				end else
					bad = 1'b1;
			end
			ST_SP_VALUE: if (c == CHAR_SP) parser_state = ST_VALUE; else bad = 1'b1;
			ST_VALUE: begin
				if (c == CHAR_CR)
					parser_state = ST_NL2;
				else if (control_char(c))
					bad = 1'b1;
				else begin
					r.cls = CLASS_VALUE;
					length_step(c);
				end
			end
			ST_NL2: if (c == CHAR_LF) parser_state = ST_LINE_START; else bad = 1'b1;
			ST_NL3: begin
				if (c == CHAR_LF) begin
					parser_state = ST_BODY;
					if (length_value == 0)
						r.status = STATUS_DONE;
				end else
					bad = 1'b1;
			end
			ST_BODY: begin
				r.cls = CLASS_BODY;
				if (body_count != LENGTH_MAX)
					body_count++;
				if (body_count >= length_value)
					r.status = STATUS_DONE;
			end
			default: bad = 1'b1;
		endcase
		if (bad) begin
			r.status = STATUS_BAD;
			r.cls = CLASS_SYNTAX;
			r.header_begin = 1'b0;
		end
		r.major = major_count;
		r.minor = minor_count;
		r.body_length = length_value;
		if (r.status != STATUS_MORE)
			clear_parser();
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		$display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
	endtask

	task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	task automatic check_result();
		parse_result_t want;
		if (pending_results.size() == 0) begin
			report_mismatch("result with no request pending", result_chan.byte_out, 0);
			return;
		end
		want = pending_results.pop_front();
		results_seen++;
		check_field("status", result_chan.status, want.status);
		check_field("byte_class", result_chan.byte_class, want.cls);
		check_field("byte_out", result_chan.byte_out, want.data);
		check_field("header_begin", result_chan.header_begin, want.header_begin);
		check_field("major_version", result_chan.major_version, want.major);
		check_field("minor_version", result_chan.minor_version, want.minor);
		check_field("body_length", result_chan.body_length, want.body_length);
	endtask

	always @(posedge clk) begin
		if (arst_n && result_chan.valid && result_chan.ready)
			check_result();
	end

	// result side: random stall bursts plus one long hold
	initial begin
		result_chan.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				result_chan.ready <= 1'b0;
				hold_cycles--;
			end else if (stall_left > 0) begin
				result_chan.ready <= 1'b0;
				stall_left--;
			end else begin
				result_chan.ready <= 1'b1;
				if (idle_on && $urandom_range(0, 15) == 0)
					stall_left = $urandom_range(1, 19);
			end
		end
	end

	task automatic send_byte(logic [7:0] data, bit pinned = 1'b0,
			status_t pin_status = STATUS_MORE, byte_class_t pin_cls = CLASS_SYNTAX);
		parse_result_t r;
		if (gap_mode && idle_on && $urandom_range(0, 5) == 0) begin
			byte_chan.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		byte_chan.valid <= 1'b1;
		byte_chan.byte_in <= data;
		@(posedge clk);
		while (!byte_chan.ready)
			@(posedge clk);
		r = parse_byte(data);
		if (pinned) begin
			r.status = pin_status;
			r.cls = pin_cls;
		end
		pending_results = {pending_results, r};
		bytes_sent++;
		if (r.status == STATUS_DONE)
			requests_done++;
		else if (r.status == STATUS_BAD)
			requests_bad++;
	endtask

	function automatic logic [7:0] random_token();
		logic [7:0] c;
		do
			c = 8'($urandom_range(33, 126));
		while (!token_char(c));
		return c;
	endfunction

	// printable or high byte, never a digit so among header values only length headers carry digits
	function automatic logic [7:0] random_text();
		logic [7:0] c;
		c = 8'($urandom_range(32, 255));
		if (c == CHAR_DEL || digit_char(c))
			c = c ^ 8'h40;
		return c;
	endfunction

	function automatic logic [7:0] random_digit();
		return 8'(8'h30 + $urandom_range(0, 9));
	endfunction

	task automatic add_byte(logic [7:0] c);
		request_bytes = {request_bytes, c};
	endtask

	task automatic add_text(string s, bit mixed_case);
		logic [7:0] c;
		for (int i = 0; i < s.len(); i++) begin
			c = s[i];
			if (mixed_case && c >= "a" && c <= "z" && $urandom_range(0, 1))
				c = c - 8'h20;
			add_byte(c);
		end
	endtask

	task automatic add_line_end();
		add_byte(CHAR_CR);
		add_byte(CHAR_LF);
	endtask

	task automatic build_request();
		int headers;
		int digits;
		int pick;
		int spot;
		bit huge;
		bit is_length;
		logic [7:0] c;
		request_bytes = {};
		huge = $urandom_range(0, 14) == 0;
		headers = $urandom_range(huge ? 1 : 0, 4);
		repeat ($urandom_range(1, 6))
			add_byte(random_token());
		add_byte(CHAR_SP);
		repeat ($urandom_range(1, 8)) begin
			c = random_text();
			add_byte(c == CHAR_SP ? 8'h2f : c);
		end
		add_byte(CHAR_SP);
		add_text("HTTP/", 1'b0);
		repeat ($urandom_range(1, 3))
			add_byte(random_digit());
		add_byte(".");
		repeat ($urandom_range(1, 3))
			add_byte(random_digit());
		add_line_end();
		for (int h = 0; h < headers; h++) begin
			is_length = 1'b0;
			digits = 0;
			pick = (huge && h == headers - 1) ? 0 : $urandom_range(0, 9);
			case (pick)
				0, 1, 2, 3: begin
					add_text("content-length", 1'b1);
					is_length = 1'b1;
				end
				4: add_text("content-len", 1'b1);
				5: begin
					add_text("content-length", 1'b1);
					add_byte(random_token());
				end
				default: repeat ($urandom_range(1, 6)) add_byte(random_token());
			endcase
			add_byte(":");
			add_byte(CHAR_SP);
			if (is_length) begin
				repeat ($urandom_range(0, 2))
					add_byte(CHAR_SP);
				if ($urandom_range(0, 5) == 0)
					add_byte($urandom_range(0, 1) ? 8'h2b : 8'h2d);
				if (huge && h == headers - 1) begin
					add_text("9", 1'b0);
					digits = 10;
				end else
					digits = $urandom_range(0, 2);
				repeat (digits)
					add_byte(random_digit());
				if (digits > 0 && $urandom_range(0, 3) == 0)
					add_text(" 7", 1'b0);
			end else begin
				repeat ($urandom_range(0, 8))
					add_byte(random_text());
			end
			add_line_end();
			// saturated length unless signed: never send that body, break the request instead
			if (huge && h == headers - 1) begin
				add_byte(8'h00);
				return;
			end
			if ($urandom_range(0, 4) == 0) begin
				add_byte($urandom_range(0, 1) ? CHAR_SP : CHAR_TAB);
				repeat ($urandom_range(0, 2))
					add_byte(CHAR_SP);
				if (is_length && digits <= 1) begin
					add_byte(random_digit());
					digits++;
				end else begin
					repeat ($urandom_range(0, 3))
						add_byte(random_text());
				end
				add_line_end();
			end
		end
		add_line_end();
		if ($urandom_range(0, 4) == 0) begin
			spot = $urandom_range(0, request_bytes.size() - 1);
			c = 8'($urandom_range(0, 255));
			if (digit_char(c))
				c = c ^ 8'h40;
			request_bytes[spot] = c;
		end
	endtask

	task automatic send_request();
		// a leftover partial request is flushed by a control byte
		if (parser_state != ST_METHOD_START)
			send_byte(8'h00);
		foreach (request_bytes[i])
			send_byte(request_bytes[i]);
		while (parser_state == ST_BODY)
			send_byte(8'($urandom_range(0, 255)));
	endtask

	initial begin
		int guard;
		arst_n <= 1'b0;
		byte_chan.valid <= 1'b0;
		byte_chan.byte_in <= '0;
		clear_parser();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (opening_bytes[i])
			send_byte(opening_bytes[i].data, opening_bytes[i].pinned, opening_bytes[i].status,
				opening_bytes[i].cls);
		byte_chan.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		hold_cycles = HOLD_LENGTH;
		while (bytes_sent < BYTE_TARGET) begin
			if (bytes_sent >= QUIET_FROM)
				idle_on = 1'b0;
			gap_mode = $urandom_range(0, 2) != 0;
			build_request();
			send_request();
		end
		byte_chan.valid <= 1'b0;
		for (guard = 0; guard < 5000 && pending_results.size() != 0; guard++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results never arrived", pending_results.size(), 0);
		$display("%0d request bytes sent, %0d results checked", bytes_sent, results_seen);
		$display("%0d requests completed, %0d malformed bytes, incl. folded and saturated lengths",
			requests_done, requests_bad);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
hdl/hrbp_pkg.sv
hdl/hrbp_if.sv
hdl/hrbp_char_class.sv
hdl/hrbp_step.sv
hdl/http_request_byte_parser_unit.sv
hdl/hrbp_checker.sv
tb/http_request_byte_parser_unit_test.sv
